// ===== hw/rtl/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// apm_pkg: shared types and constants of the automaton pattern matcher
// Register indexes, beat layouts, cell control and pattern byte lookup.
// ----------------------------------------------------------------------------
package apm_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int BYTE_BITS      = 8;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int LENGTH_BITS    = 5;
   // wide enough for any pattern length up to the largest cell count
   localparam int EFF_LEN_BITS   = 7;
   localparam int START_BITS     = 32;
   localparam int RSP_DATA_BITS  = 40;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic                 advance;
      logic                 flush;
      logic [BYTE_BITS-1:0] text_byte;
   } cell_ctrl_type;

   typedef struct packed {
      logic                     last;
      logic [RSP_DATA_BITS-1:0] data;
   } rsp_beat_type;

   // pattern byte k; bytes beyond the two registers read as zero
   function automatic logic [BYTE_BITS-1:0] pattern_byte(
      input logic [CSR_DATA_BITS-1:0] low,
      input logic [CSR_DATA_BITS-1:0] high,
      input int                       k
   );
      logic [BYTE_BITS-1:0] b;
      b = '0;
      if (k < 8) begin
         b = low[8*k +: 8];
      end else if (k < 16) begin
         b = high[8*(k-8) +: 8];
      end
      return b;
   endfunction

endpackage

// ===== hw/rtl/automaton_pattern_matcher_unit.sv =====
// Each response beat is registered in the output buffer before it shows on rsp_tvalid.
// Throughput: one text byte per cycle while req_tready is high; each byte updates every cell in one step.
// A stalled result is held in a two-entry output buffer, so one more beat is taken meanwhile.
// Reset clears prefix cells, position, seen flag, buffer and registers (length reads as 1).
// ----------------------------------------------------------------------------
// automaton_pattern_matcher_unit: streaming pattern matcher, top level
// A chain of prefix cells tracks every pattern prefix that ends at the
// current byte; the cell at the pattern length flags a full occurrence.
// ----------------------------------------------------------------------------
module automaton_pattern_matcher_unit
   import apm_pkg::*;
#(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_BITS-1:0]      req_tdata,   // [7:0] text_byte
   input  logic                      req_tlast,   // end_of_text
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [0] match_found, [32:1] match_start,
                                                  // [33] any_match, [39:34] zero
   output logic                      rsp_tlast,   // text_done
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SUM_BITS = (POSITION_BITS + 1 > START_BITS + 1) ? POSITION_BITS + 1
                                                                  : START_BITS + 1;

   logic [CSR_DATA_BITS-1:0] pat_low_ff, pat_low_in;
   logic [CSR_DATA_BITS-1:0] pat_high_ff, pat_high_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     seen_ff, seen_in;

   logic                     csr_write;
   logic                     csr_known;
   logic                     req_accept;
   logic                     buf_ready;
   logic [EFF_LEN_BITS-1:0]  eff_len;
   logic [PATTERN_MAX-1:0]   len_sel;
   logic [PATTERN_MAX-1:0]   prefix_vec;
   logic [PATTERN_MAX-1:0]   step_vec;
   logic                     hit;
   logic [SUM_BITS-1:0]      idx_plus;
   logic [SUM_BITS-1:0]      len_wide;
   logic [SUM_BITS-1:0]      start_wide;
   logic [START_BITS-1:0]    match_start;
   cell_ctrl_type            ctrl;
   rsp_beat_type             beat_in;
   rsp_beat_type             beat_out;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      length_in   = length_ff;
      csr_known   = 1'b0;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW: begin
               pat_low_in = csr_data;
               csr_known  = 1'b1;
            end
            CSR_PATTERN_HIGH: begin
               pat_high_in = csr_data;
               csr_known   = 1'b1;
            end
            CSR_PATTERN_LENGTH: begin
               length_in = csr_data[LENGTH_BITS-1:0];
               csr_known = 1'b1;
            end
            default: begin
               csr_known = 1'b0;
            end
         endcase
      end
   end

   // effective length: zero reads as one, clamp to the cell count
   always_comb begin
      if (length_ff == '0) begin
         eff_len = EFF_LEN_BITS'(1);
      end else if (EFF_LEN_BITS'(length_ff) > EFF_LEN_BITS'(PATTERN_MAX)) begin
         eff_len = EFF_LEN_BITS'(PATTERN_MAX);
      end else begin
         eff_len = EFF_LEN_BITS'(length_ff);
      end
   end

   assign ctrl.advance   = req_accept;
   assign ctrl.flush     = csr_known || (req_accept && req_tlast);
   assign ctrl.text_byte = req_tdata;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic prev_match;
      if (k == 0) begin : g_head
         assign prev_match = 1'b1;
      end else begin : g_link
         assign prev_match = prefix_vec[k-1];
      end
      assign len_sel[k] = (eff_len == EFF_LEN_BITS'(k + 1));

      apm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .pattern_char (pattern_byte(pat_low_ff, pat_high_ff, k)),
         .prev_match   (prev_match),
         .prefix_match (prefix_vec[k]),
         .step_match   (step_vec[k])
      );
   end

   assign hit = |(step_vec & len_sel);

   // start index of the occurrence ending at this byte
   assign idx_plus   = SUM_BITS'(position_ff) + SUM_BITS'(1);
   assign len_wide   = SUM_BITS'(eff_len);
   assign start_wide = idx_plus - len_wide;
   assign match_start = (hit && (idx_plus >= len_wide)) ? start_wide[START_BITS-1:0]
                                                        : '0;

   always_comb begin
      position_in = position_ff;
      seen_in     = seen_ff;
      if (req_accept) begin
         if (req_tlast) begin
            position_in = '0;
            seen_in     = 1'b0;
         end else begin
            if (position_ff != '1) begin
               position_in = position_ff + POSITION_BITS'(1);
            end
            seen_in = seen_ff || hit;
         end
      end
   end

   assign beat_in.last = req_tlast;
   assign beat_in.data = RSP_DATA_BITS'({req_tlast && (seen_ff || hit), match_start, hit});

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         length_ff   <= LENGTH_BITS'(1);
         position_ff <= '0;
         seen_ff     <= 1'b0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         seen_ff     <= seen_in;
      end
   end

   apm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (buf_ready),
      .in_beat   (beat_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (beat_out)
   );

   assign rsp_tdata = beat_out.data;
   assign rsp_tlast = beat_out.last;

`ifndef ASSERT_OFF
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   a_start_zero_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[32:1] == '0))
      else $error("match start nonzero without a match");

   a_any_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33]) |-> rsp_tlast)
      else $error("any-match flag on a beat that does not end the text");

   a_text_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (position_ff == '0 && !seen_ff && prefix_vec == '0))
      else $error("text state not cleared after the last byte");

   a_csr_clears_cells: assert property (@(posedge clock) disable iff (reset)
      csr_known |=> (prefix_vec == '0))
      else $error("prefix cells not cleared after a register write");
`endif

endmodule

// ===== hw/rtl/apm_cell.sv =====
// ----------------------------------------------------------------------------
// apm_cell: one prefix cell of the matcher chain
// Holds whether the pattern prefix ending at this cell's byte matches the
// text up to the last byte, and hands that bit to its right neighbor.
// ----------------------------------------------------------------------------
module apm_cell
   import apm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [BYTE_BITS-1:0] pattern_char,
   input  logic                 prev_match,
   output logic                 prefix_match,
   output logic                 step_match
);

   logic prefix_match_ff;
   logic prefix_match_in;

   assign step_match   = prev_match && (ctrl.text_byte == pattern_char);
   assign prefix_match = prefix_match_ff;

   always_comb begin
      prefix_match_in = prefix_match_ff;
      if (ctrl.flush) begin
         prefix_match_in = 1'b0;
      end else if (ctrl.advance) begin
         prefix_match_in = step_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_match_ff <= 1'b0;
      end else begin
         prefix_match_ff <= prefix_match_in;
      end
   end

endmodule

// ===== hw/rtl/apm_out_buf.sv =====
// ----------------------------------------------------------------------------
// apm_out_buf: two-entry output register with skid stage
// Keeps the result side from stalling the input side for one beat.
// ----------------------------------------------------------------------------
module apm_out_buf
   import apm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_beat_type in_beat,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_beat_type out_beat
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type main_ff, main_in;
   rsp_beat_type skid_ff, skid_in;
   logic         accept;
   logic         main_free;

   assign in_ready  = !skid_valid_ff;
   assign accept    = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;
   assign out_valid = main_valid_ff;
   assign out_beat  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept;
            main_in       = in_beat;
         end
      end else if (accept) begin
         // main is stalled: park the beat
         skid_valid_in = 1'b1;
         skid_in       = in_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
